@@ src/bed_pkg.sv @@
// Shared types, character codes and helper functions for the escape decoder.
`default_nettype none
package bed_pkg;

  localparam int MAX_RES = 10;
  localparam int POS_W   = 4;
  localparam int HELD_N  = 8;

  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_BACKSLASH = 3'd1;
  localparam logic [2:0] PH_HEX_X     = 3'd2;
  localparam logic [2:0] PH_HEX_U     = 3'd3;
  localparam logic [2:0] PH_HEX_BIG_U = 3'd4;

  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_DOLL  = 8'h24;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_BIG_U = 8'h55;

  localparam logic [7:0] CODE_BS  = 8'd8;
  localparam logic [7:0] CODE_ESC = 8'd27;
  localparam logic [7:0] CODE_LF  = 8'd10;
  localparam logic [7:0] CODE_CR  = 8'd13;
  localparam logic [7:0] CODE_TAB = 8'd9;

  typedef struct packed {
    logic               ok;
    logic [3:0]         val;
  } hex_t;

  typedef struct packed {
    logic [MAX_RES-1:0][7:0] bytes;
    logic [POS_W-1:0]        count;
    logic                    last;
  } res_t;

  function automatic hex_t hex_value(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b0;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.ok  = 1'b1;
      h.val = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      h.ok  = 1'b1;
      h.val = c[3:0] + 4'd9;
    end
    return h;
  endfunction

  function automatic logic [7:0] hex_letter(input logic [2:0] ph);
    logic [7:0] l;
    case (ph)
      PH_HEX_X: l = CH_X;
      PH_HEX_U: l = CH_U;
      default:  l = CH_BIG_U;
    endcase
    return l;
  endfunction

  function automatic logic [3:0] digits_needed(input logic [2:0] ph);
    logic [3:0] d;
    case (ph)
      PH_HEX_X: d = 4'd2;
      PH_HEX_U: d = 4'd4;
      default:  d = 4'd8;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

@@ src/bed_decode.sv @@
// Escape state and combinational decode of one source byte into its output list.
`default_nettype none
module bed_decode (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         take,
  input  wire logic [7:0]   in_byte,
  input  wire logic         in_last,
  output bed_pkg::res_t     res
);

  logic [2:0]  phase_r, phase_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [31:0] code_r, code_nxt;
  logic [bed_pkg::HELD_N-1:0][7:0] held_r, held_nxt;

  always_comb begin
    logic [bed_pkg::MAX_RES-1:0][7:0] b;
    logic [bed_pkg::POS_W-1:0] n;
    logic [2:0]  ph;
    logic [3:0]  cnt;
    logic [31:0] code;
    logic [bed_pkg::HELD_N-1:0][7:0] held;
    logic        do_idle;
    logic        do_flush;
    bed_pkg::hex_t hv;
    b        = '0;
    n        = '0;
    ph       = phase_r;
    cnt      = cnt_r;
    code     = code_r;
    held     = held_r;
    do_idle  = 1'b0;
    do_flush = 1'b0;
    hv       = bed_pkg::hex_value(in_byte);

    if (ph == bed_pkg::PH_BACKSLASH) begin
      ph = bed_pkg::PH_IDLE;
      case (in_byte)
        bed_pkg::CH_BSL:  begin b[0] = bed_pkg::CH_BSL;   n = 4'd1; end
        bed_pkg::CH_ZERO: begin b[0] = 8'd0;              n = 4'd1; end
        bed_pkg::CH_DQ:   begin b[0] = bed_pkg::CH_DQ;    n = 4'd1; end
        bed_pkg::CH_SQ:   begin b[0] = bed_pkg::CH_SQ;    n = 4'd1; end
        bed_pkg::CH_DOLL: begin b[0] = bed_pkg::CH_DOLL;  n = 4'd1; end
        bed_pkg::CH_B:    begin b[0] = bed_pkg::CODE_BS;  n = 4'd1; end
        bed_pkg::CH_E:    begin b[0] = bed_pkg::CODE_ESC; n = 4'd1; end
        bed_pkg::CH_N:    begin b[0] = bed_pkg::CODE_LF;  n = 4'd1; end
        bed_pkg::CH_R:    begin b[0] = bed_pkg::CODE_CR;  n = 4'd1; end
        bed_pkg::CH_T:    begin b[0] = bed_pkg::CODE_TAB; n = 4'd1; end
        bed_pkg::CH_X: begin
          ph = bed_pkg::PH_HEX_X; cnt = 4'd0; code = '0;
        end
        bed_pkg::CH_U: begin
          ph = bed_pkg::PH_HEX_U; cnt = 4'd0; code = '0;
        end
        bed_pkg::CH_BIG_U: begin
          ph = bed_pkg::PH_HEX_BIG_U; cnt = 4'd0; code = '0;
        end
        default: begin
          b[0] = bed_pkg::CH_BSL;
          b[1] = in_byte;
          n    = 4'd2;
        end
      endcase
    end else if (ph == bed_pkg::PH_HEX_X || ph == bed_pkg::PH_HEX_U ||
                 ph == bed_pkg::PH_HEX_BIG_U) begin
      if (hv.ok) begin
        held[cnt[2:0]] = in_byte;
        code = {code[27:0], hv.val};
        cnt  = cnt + 4'd1;
        if (cnt >= bed_pkg::digits_needed(ph)) begin
          if (ph == bed_pkg::PH_HEX_X) begin
            b[0] = code[7:0];
            n    = 4'd1;
          end else if (code < 32'h80) begin
            b[0] = code[7:0];
            n    = 4'd1;
          end else if (code < 32'h800) begin
            b[0] = {3'b110, code[10:6]};
            b[1] = {2'b10, code[5:0]};
            n    = 4'd2;
          end else if (code < 32'h10000) begin
            b[0] = {4'b1110, code[15:12]};
            b[1] = {2'b10, code[11:6]};
            b[2] = {2'b10, code[5:0]};
            n    = 4'd3;
          end else if (code <= 32'h10FFFF) begin
            b[0] = {5'b11110, code[20:18]};
            b[1] = {2'b10, code[17:12]};
            b[2] = {2'b10, code[11:6]};
            b[3] = {2'b10, code[5:0]};
            n    = 4'd4;
          end
          ph   = bed_pkg::PH_IDLE;
          cnt  = 4'd0;
          code = '0;
        end
      end else begin
        do_flush = 1'b1;
        do_idle  = 1'b1;
      end
    end else begin
      do_idle = 1'b1;
    end

    if (in_last && !do_flush && (ph == bed_pkg::PH_HEX_X ||
        ph == bed_pkg::PH_HEX_U || ph == bed_pkg::PH_HEX_BIG_U)) begin
      do_flush = 1'b1;
    end

    // An unfinished hex sequence is always flushed at the head of the list.
    if (do_flush) begin
      b[0] = bed_pkg::CH_BSL;
      b[1] = bed_pkg::hex_letter(ph);
      for (int k = 0; k < bed_pkg::HELD_N - 1; k++) begin
        if (4'(k) < cnt) begin
          b[4'(k + 2)] = held[3'(k)];
        end
      end
      n    = cnt + 4'd2;
      ph   = bed_pkg::PH_IDLE;
      cnt  = 4'd0;
      code = '0;
    end

    if (do_idle) begin
      ph = bed_pkg::PH_IDLE;
      if (in_byte == bed_pkg::CH_BSL) begin
        ph = bed_pkg::PH_BACKSLASH;
      end else if (n < 4'(bed_pkg::MAX_RES)) begin
        b[n] = in_byte;
        n    = n + 4'd1;
      end
    end

    if (in_last) begin
      if (ph == bed_pkg::PH_BACKSLASH && n < 4'(bed_pkg::MAX_RES)) begin
        b[n] = bed_pkg::CH_BSL;
        n    = n + 4'd1;
      end
      ph   = bed_pkg::PH_IDLE;
      cnt  = 4'd0;
      code = '0;
    end

    res.bytes = b;
    res.count = n;
    res.last  = in_last;
    phase_nxt = ph;
    cnt_nxt   = cnt;
    code_nxt  = code;
    held_nxt  = held;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= bed_pkg::PH_IDLE;
      cnt_r   <= 4'd0;
      code_r  <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      code_r  <= code_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held_r <= held_nxt;
    end
  end

endmodule
`default_nettype wire

@@ src/bed_drain.sv @@
// Result list buffer and output register that hand out one byte per transaction.
`default_nettype none
module bed_drain (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          load,
  input  wire bed_pkg::res_t res,
  output logic               buf_free,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [7:0]         out_byte,
  output logic               out_run_last,
  output logic               out_string_end
);

  logic [bed_pkg::MAX_RES-1:0][7:0] buf_r;
  logic [bed_pkg::POS_W-1:0]        cnt_r;
  logic [bed_pkg::POS_W-1:0]        ptr_r;
  logic                             end_r;
  logic                             buf_vld_r;
  logic                             oval_r;
  logic [7:0]                       obyte_r;
  logic                             orun_r;
  logic                             oend_r;
  logic                             move;
  logic                             final_pos;

  assign move      = buf_vld_r && (!oval_r || out_ready);
  assign final_pos = (ptr_r == cnt_r - 4'd1);
  assign buf_free  = !buf_vld_r || (move && final_pos);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_vld_r <= 1'b0;
      ptr_r     <= '0;
      oval_r    <= 1'b0;
    end else begin
      if (load) begin
        buf_vld_r <= 1'b1;
        ptr_r     <= '0;
      end else if (move) begin
        if (final_pos) begin
          buf_vld_r <= 1'b0;
        end
        ptr_r <= ptr_r + 4'd1;
      end
      if (move) begin
        oval_r <= 1'b1;
      end else if (out_ready) begin
        oval_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_r <= res.bytes;
      cnt_r <= res.count;
      end_r <= res.last;
    end
    if (move) begin
      obyte_r <= buf_r[ptr_r];
      orun_r  <= final_pos;
      oend_r  <= final_pos && end_r;
    end
  end

  assign out_valid      = oval_r;
  assign out_byte       = obyte_r;
  assign out_run_last   = orun_r;
  assign out_string_end = oend_r;

endmodule
`default_nettype wire

@@ src/backslash_escape_decoder.sv @@
// Top level of the backslash escape decoder.
`default_nettype none
// Decodes a byte stream with backslash escapes (\\ \0 \" \' \$ \b \e \n \r \t,
// \xHH, \uHHHH and \UHHHHHHHH written out as UTF-8). Each input transaction
// is decoded in the cycle it is accepted and yields zero to ten output bytes,
// which leave one per cycle through an output register while out_ready is high.
// Plain text streams at one byte per cycle; an input that yields more than
// one byte holds off the next input while the result buffer drains.
// out_run_last marks the last byte caused by one input and out_string_end
// the last byte of a string whose final input had in_last set.
module backslash_escape_decoder (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_run_last,
  output logic            out_string_end
);

  logic          take;
  bed_pkg::res_t res;

  assign take = in_valid && in_ready;

  bed_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .in_byte (in_byte),
    .in_last (in_last),
    .res     (res)
  );

  bed_drain u_drain (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (take && (res.count != '0)),
    .res            (res),
    .buf_free       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_run_last   (out_run_last),
    .out_string_end (out_string_end)
  );

endmodule
`default_nettype wire

@@ test/tb_backslash_escape_decoder.sv @@
// Self-checking testbench for the escape decoder: directed and random strings against a predictor.
`default_nettype none
module tb_backslash_escape_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_BYTES = 240;

  typedef struct packed {
    logic [7:0] value;
    logic       run_last;
    logic       string_end;
  } decoded_t;

  class escape_scoreboard;
    logic [2:0]  phase;
    logic [3:0]  digit_count;
    logic [31:0] code_point;
    logic [7:0]  held [bed_pkg::HELD_N];
    logic [7:0]  step_bytes [$];
    decoded_t    decoded_q [$];
    int          error_count;

    function new();
      phase       = bed_pkg::PH_IDLE;
      digit_count = 4'd0;
      code_point  = 32'd0;
      error_count = 0;
    endfunction

    static function bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
      v = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
        v = 4'(c - 8'h30);
        return 1'b1;
      end
      if (c >= 8'h41 && c <= 8'h46) begin
        v = 4'(c - 8'h37);
        return 1'b1;
      end
      if (c >= 8'h61 && c <= 8'h66) begin
        v = 4'(c - 8'h57);
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void put(input logic [7:0] b);
      if (step_bytes.size() < bed_pkg::MAX_RES) step_bytes.push_back(b);
    endfunction

    function void put_utf8(input logic [31:0] cp);
      if (cp < 32'h80) begin
        put(cp[7:0]);
      end else if (cp < 32'h800) begin
        put({3'b110, cp[10:6]});
        put({2'b10, cp[5:0]});
      end else if (cp < 32'h10000) begin
        put({4'b1110, cp[15:12]});
        put({2'b10, cp[11:6]});
        put({2'b10, cp[5:0]});
      end else if (cp <= 32'h10FFFF) begin
        put({5'b11110, cp[20:18]});
        put({2'b10, cp[17:12]});
        put({2'b10, cp[11:6]});
        put({2'b10, cp[5:0]});
      end
    endfunction

    function void clear_hex();
      phase       = bed_pkg::PH_IDLE;
      digit_count = 4'd0;
      code_point  = 32'd0;
    endfunction

    function bit in_hex();
      return phase == bed_pkg::PH_HEX_X || phase == bed_pkg::PH_HEX_U ||
             phase == bed_pkg::PH_HEX_BIG_U;
    endfunction

    function void flush_hex();
      put(bed_pkg::CH_BSL);
      case (phase)
        bed_pkg::PH_HEX_X: put(bed_pkg::CH_X);
        bed_pkg::PH_HEX_U: put(bed_pkg::CH_U);
        default:           put(bed_pkg::CH_BIG_U);
      endcase
      for (int k = 0; k < int'(digit_count) && k < bed_pkg::HELD_N; k++) put(held[k]);
      clear_hex();
    endfunction

    function void decode_char(input logic [7:0] c);
      logic [3:0] v;
      int         needed;
      if (phase == bed_pkg::PH_BACKSLASH) begin
        phase = bed_pkg::PH_IDLE;
        case (c)
          bed_pkg::CH_BSL:   put(bed_pkg::CH_BSL);
          bed_pkg::CH_ZERO:  put(8'h00);
          bed_pkg::CH_DQ:    put(bed_pkg::CH_DQ);
          bed_pkg::CH_SQ:    put(bed_pkg::CH_SQ);
          bed_pkg::CH_DOLL:  put(bed_pkg::CH_DOLL);
          bed_pkg::CH_B:     put(bed_pkg::CODE_BS);
          bed_pkg::CH_E:     put(bed_pkg::CODE_ESC);
          bed_pkg::CH_N:     put(bed_pkg::CODE_LF);
          bed_pkg::CH_R:     put(bed_pkg::CODE_CR);
          bed_pkg::CH_T:     put(bed_pkg::CODE_TAB);
          bed_pkg::CH_X:     begin clear_hex(); phase = bed_pkg::PH_HEX_X; end
          bed_pkg::CH_U:     begin clear_hex(); phase = bed_pkg::PH_HEX_U; end
          bed_pkg::CH_BIG_U: begin clear_hex(); phase = bed_pkg::PH_HEX_BIG_U; end
          default: begin
            put(bed_pkg::CH_BSL);
            put(c);
          end
        endcase
        return;
      end
      if (in_hex()) begin
        if (hex_nibble(c, v)) begin
          held[digit_count[2:0]] = c;
          code_point  = {code_point[27:0], v};
          digit_count = digit_count + 4'd1;
          needed = (phase == bed_pkg::PH_HEX_X) ? 2 :
                   ((phase == bed_pkg::PH_HEX_U) ? 4 : 8);
          if (int'(digit_count) >= needed) begin
            if (phase == bed_pkg::PH_HEX_X) put(code_point[7:0]);
            else put_utf8(code_point);
            clear_hex();
          end
          return;
        end
        flush_hex();
      end
      phase = bed_pkg::PH_IDLE;
      if (c == bed_pkg::CH_BSL) phase = bed_pkg::PH_BACKSLASH;
      else put(c);
    endfunction

    function void note_source_byte(input logic [7:0] c, input logic last);
      int n;
      step_bytes.delete();
      decode_char(c);
      if (last) begin
        if (phase == bed_pkg::PH_BACKSLASH) put(bed_pkg::CH_BSL);
        else if (in_hex()) flush_hex();
        clear_hex();
      end
      n = step_bytes.size();
      for (int k = 0; k < n; k++)
        decoded_q.push_back('{step_bytes[k], k == n - 1, (k == n - 1) && last});
    endfunction

    function void check_decoded_byte(input logic [7:0] b, input logic rl, input logic se);
      decoded_t exp_d;
      if (decoded_q.size() == 0) begin
        $error("unexpected transaction: out_byte %h run_last %b string_end %b", b, rl, se);
        error_count++;
        return;
      end
      exp_d = decoded_q.pop_front();
      if (b !== exp_d.value) begin
        $error("out_byte: expected %h, actual %h", exp_d.value, b);
        error_count++;
      end
      if (rl !== exp_d.run_last) begin
        $error("out_run_last: expected %b, actual %b", exp_d.run_last, rl);
        error_count++;
      end
      if (se !== exp_d.string_end) begin
        $error("out_string_end: expected %b, actual %b", exp_d.string_end, se);
        error_count++;
      end
    endfunction

    function int pending();
      return decoded_q.size();
    endfunction
  endclass

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic [7:0] in_byte   = 8'h00;
  logic       in_last   = 1'b0;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_run_last;
  logic       out_string_end;

  int cycle_count = 0;
  int random_sent = 0;

  escape_scoreboard sb = new();

  backslash_escape_decoder u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_run_last   (out_run_last),
    .out_string_end (out_string_end)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_source_byte(in_byte, in_last);
      if (out_valid && out_ready) sb.check_decoded_byte(out_byte, out_run_last, out_string_end);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return bed_pkg::CH_ZERO + 8'(v);
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
  endfunction

  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  task automatic send_char(input logic [7:0] b, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_text(input string s, input bit close_string);
    int i;
    for (i = 0; i < s.len(); i++) send_char(s[i], close_string && (i == s.len() - 1));
  endtask

  task automatic send_random_char(input logic [7:0] b);
    send_char(b, $urandom_range(0, 39) == 0);
    random_sent++;
  endtask

  task automatic send_random_hex(input logic [31:0] value, input int n);
    int i;
    for (i = n - 1; i >= 0; i--) send_random_char(hex_char(value[4*i +: 4]));
  endtask

  function automatic logic [31:0] pick_code_point(input int classes);
    case ($urandom_range(0, classes - 1))
      0:       return $urandom_range(0, 32'h7F);
      1:       return $urandom_range(32'h80, 32'h7FF);
      2:       return $urandom_range(32'h800, 32'hFFFF);
      default: return $urandom_range(32'h10000, 32'h10FFFF);
    endcase
  endfunction

  task automatic send_random_unit();
    logic [7:0] simple_esc [10];
    logic [7:0] c;
    logic [3:0] v;
    logic [31:0] cp;
    int kind;
    int ph;
    int needed;
    simple_esc = '{bed_pkg::CH_BSL, bed_pkg::CH_ZERO, bed_pkg::CH_DQ, bed_pkg::CH_SQ,
                   bed_pkg::CH_DOLL, bed_pkg::CH_B, bed_pkg::CH_E, bed_pkg::CH_N,
                   bed_pkg::CH_R, bed_pkg::CH_T};
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      do c = 8'($urandom_range(0, 255)); while (c == bed_pkg::CH_BSL);
      send_random_char(c);
    end else if (kind < 50) begin
      send_random_char(bed_pkg::CH_BSL);
      send_random_char(simple_esc[$urandom_range(0, 9)]);
    end else if (kind < 60) begin
      send_random_char(bed_pkg::CH_BSL);
      send_random_char(bed_pkg::CH_X);
      send_random_hex($urandom_range(0, 255), 2);
    end else if (kind < 70) begin
      send_random_char(bed_pkg::CH_BSL);
      send_random_char(bed_pkg::CH_U);
      send_random_hex(pick_code_point(3), 4);
    end else if (kind < 78) begin
      if ($urandom_range(0, 9) == 0) cp = $urandom_range(32'h110000, 32'hFFFFFFFF);
      else cp = pick_code_point(4);
      send_random_char(bed_pkg::CH_BSL);
      send_random_char(bed_pkg::CH_BIG_U);
      send_random_hex(cp, 8);
    end else if (kind < 88) begin
      ph = $urandom_range(0, 2);
      needed = (ph == 0) ? 2 : ((ph == 1) ? 4 : 8);
      send_random_char(bed_pkg::CH_BSL);
      send_random_char((ph == 0) ? bed_pkg::CH_X :
                       ((ph == 1) ? bed_pkg::CH_U : bed_pkg::CH_BIG_U));
      send_random_hex($urandom, $urandom_range(0, needed - 1));
      do c = 8'($urandom_range(0, 255)); while (escape_scoreboard::hex_nibble(c, v));
      send_random_char(c);
    end else if (kind < 94) begin
      do c = 8'($urandom_range(0, 255));
      while (c inside {bed_pkg::CH_BSL, bed_pkg::CH_ZERO, bed_pkg::CH_DQ, bed_pkg::CH_SQ,
                       bed_pkg::CH_DOLL, bed_pkg::CH_B, bed_pkg::CH_E, bed_pkg::CH_N,
                       bed_pkg::CH_R, bed_pkg::CH_T, bed_pkg::CH_X, bed_pkg::CH_U,
                       bed_pkg::CH_BIG_U});
      send_random_char(bed_pkg::CH_BSL);
      send_random_char(c);
    end else begin
      send_random_char(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h41, 1'b1);
    send_text("\\\\\\0\\\"\\'\\$\\b\\e\\n\\r\\t", 1'b1);
    send_text("\\x41\\xfF\\x00", 1'b1);
    send_text("\\u0041\\u00e9\\u20AC\\uD800\\uFFFF", 1'b1);
    send_text("\\U0001F600\\U0010FFFF\\U00000080", 1'b1);
    send_text("\\U00110000", 1'b1);
    send_text("\\q\\x4g\\u12\\n", 1'b1);
    send_text("\\U1234567z", 1'b1);
    send_text("ab\\", 1'b1);
    send_text("\\u12", 1'b1);
    send_text("\\x\\", 1'b1);

    while (random_sent < RANDOM_BYTES) send_random_unit();
    send_char(8'h21, 1'b1);
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.error_count == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
